FILE: hdl/hsb_pkg.sv
// ----------------------------------------------------------------------------
// hsb_pkg
// Types and constants shared by the bottom-up heapsort block.
// ----------------------------------------------------------------------------
`default_nettype none

package hsb_pkg;

  localparam int STORE_DEPTH_DEF = 64;
  localparam int VAL_W           = 32;

  // One input request: an element, and the mark that ends the set.
  typedef struct packed {
    logic signed [VAL_W-1:0] value;
    logic                    last;
  } in_req_t;

  // One result: the next element in ascending order.
  typedef struct packed {
    logic signed [VAL_W-1:0] sorted_value;
    logic                    final_res;
    logic                    overflowed;
  } out_res_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic take;      // store an accepted request
    logic init;      // start a sort over the stored set
    logic bld_rd;    // read the next parent for the build phase
    logic bld_cur;   // latch the parent as the sifted value
    logic ext_rd;    // read root and end of heap
    logic ext_wr;    // move root to the end, latch end as sifted value
    logic sift_rd;   // read both children of the hole
    logic sift_cmp;  // compare and move the hole down
    logic out_rd;    // read the next sorted element
    logic out_ld;    // load the result register
  } hsb_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic i_nz;      // parents left to sift in the build phase
    logic size_gt1;  // heap still has more than one entry
    logic leaf;      // hole has no children
    logic cont;      // larger child beats the sifted value
    logic out_free;  // result register can take a new value
    logic out_final; // element being loaded is the last of the run
  } hsb_sts_t;

endpackage

`default_nettype wire

FILE: hdl/hsb_datapath.sv
// ----------------------------------------------------------------------------
// hsb_datapath
// Element store, heap indices, sift compare and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module hsb_datapath
  import hsb_pkg::*;
#(
  parameter int STORE_DEPTH = STORE_DEPTH_DEF
) (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire in_req_t  item,
  input  wire hsb_cmd_t cmd,
  output hsb_sts_t      sts,
  output logic          res_valid,
  input  wire logic     res_stall,
  output out_res_t      res
);

  localparam int IW = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
  localparam int CW = $clog2(STORE_DEPTH + 1);
  localparam int XW = IW + 2;

  logic signed [VAL_W-1:0] mem [STORE_DEPTH];
  logic signed [VAL_W-1:0] rd_a;
  logic signed [VAL_W-1:0] rd_b;
  logic signed [VAL_W-1:0] cur;

  logic [CW-1:0] count;
  logic          ovf;
  logic [CW-1:0] i;
  logic [CW-1:0] size;
  logic [CW-1:0] k;
  logic [IW-1:0] root;

  logic [XW-1:0] a_ext;
  logic [XW-1:0] b_ext;
  logic [XW-1:0] size_ext;
  logic          b_ok;
  logic          pick_b;
  logic [IW-1:0] big_idx;
  logic signed [VAL_W-1:0] big_val;
  logic          room;
  logic [IW-1:0] size_m1;
  logic [IW-1:0] i_m1;

  logic                    wr_en;
  logic [IW-1:0]           wr_addr;
  logic signed [VAL_W-1:0] wr_data;
  logic [IW-1:0]           ra;
  logic [IW-1:0]           rb;

  assign a_ext    = XW'({root, 1'b1});
  assign b_ext    = a_ext + XW'(1);
  assign size_ext = XW'(size);
  assign b_ok     = b_ext < size_ext;
  assign pick_b   = b_ok && (rd_b > rd_a);
  assign big_idx  = pick_b ? b_ext[IW-1:0] : a_ext[IW-1:0];
  assign big_val  = pick_b ? rd_b : rd_a;
  assign room     = count < CW'(STORE_DEPTH);
  assign size_m1  = IW'(size - CW'(1));
  assign i_m1     = IW'(i - CW'(1));

  assign sts.i_nz      = i != '0;
  assign sts.size_gt1  = size > CW'(1);
  assign sts.leaf      = a_ext >= size_ext;
  assign sts.cont      = big_val > cur;
  assign sts.out_free  = !res_valid || !res_stall;
  assign sts.out_final = (k + CW'(1)) == count;

  // Single write port shared by load, extraction and sifting.
  always_comb begin
    wr_en   = (cmd.take && room) || cmd.ext_wr || (cmd.sift_rd && sts.leaf) ||
              cmd.sift_cmp;
    wr_addr = root;
    wr_data = cur;
    if (cmd.take) begin
      wr_addr = count[IW-1:0];
      wr_data = item.value;
    end else if (cmd.ext_wr) begin
      wr_addr = size_m1;
      wr_data = rd_a;
    end else if (cmd.sift_cmp && sts.cont) begin
      wr_data = big_val;
    end
  end

  always_comb begin
    ra = a_ext[IW-1:0];
    rb = b_ext[IW-1:0];
    if (cmd.bld_rd) begin
      ra = i_m1;
    end else if (cmd.ext_rd) begin
      ra = '0;
      rb = size_m1;
    end else if (cmd.out_rd) begin
      ra = k[IW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_a <= mem[ra];
    rd_b <= mem[rb];
  end

  always_ff @(posedge clk) begin
    if (cmd.init) begin
      i    <= count >> 1;
      size <= count;
      k    <= '0;
    end
    if (cmd.bld_rd) begin
      i    <= i - CW'(1);
      root <= i_m1;
    end
    if (cmd.bld_cur) begin
      cur <= rd_a;
    end
    if (cmd.ext_wr) begin
      cur  <= rd_b;
      size <= size - CW'(1);
      root <= '0;
    end
    if (cmd.sift_cmp && sts.cont) begin
      root <= big_idx;
    end
    if (cmd.out_ld) begin
      k <= k + CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      ovf   <= 1'b0;
    end else if (cmd.out_ld && sts.out_final) begin
      count <= '0;
      ovf   <= 1'b0;
    end else if (cmd.take) begin
      if (room) begin
        count <= count + CW'(1);
      end else begin
        ovf <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (cmd.out_ld) begin
      res_valid <= 1'b1;
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_ld) begin
      res.sorted_value <= rd_a;
      res.final_res    <= sts.out_final;
      res.overflowed   <= ovf;
    end
  end

endmodule

`default_nettype wire

FILE: hdl/hsb_ctrl.sv
// ----------------------------------------------------------------------------
// hsb_ctrl
// Sequencer for load, heap build, extraction and result output.
// ----------------------------------------------------------------------------
`default_nettype none

module hsb_ctrl
  import hsb_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     item_valid,
  input  wire logic     item_last,
  output logic          item_stall,
  input  wire hsb_sts_t sts,
  output hsb_cmd_t      cmd
);

  localparam logic [3:0] S_LOAD     = 4'd0;
  localparam logic [3:0] S_INIT     = 4'd1;
  localparam logic [3:0] S_PICK     = 4'd2;
  localparam logic [3:0] S_BLD_CUR  = 4'd3;
  localparam logic [3:0] S_EXT_WR   = 4'd4;
  localparam logic [3:0] S_SIFT_RD  = 4'd5;
  localparam logic [3:0] S_SIFT_CMP = 4'd6;
  localparam logic [3:0] S_OUT_RD   = 4'd7;
  localparam logic [3:0] S_OUT_LD   = 4'd8;

  logic [3:0] state;
  logic [3:0] state_next;

  assign item_stall = state != S_LOAD;

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_LOAD: begin
        cmd.take = item_valid;
        if (item_valid && item_last) begin
          state_next = S_INIT;
        end
      end
      S_INIT: begin
        cmd.init   = 1'b1;
        state_next = S_PICK;
      end
      S_PICK: begin
        // build parents first, then extract until one entry remains
        if (sts.i_nz) begin
          cmd.bld_rd = 1'b1;
          state_next = S_BLD_CUR;
        end else if (sts.size_gt1) begin
          cmd.ext_rd = 1'b1;
          state_next = S_EXT_WR;
        end else begin
          state_next = S_OUT_RD;
        end
      end
      S_BLD_CUR: begin
        cmd.bld_cur = 1'b1;
        state_next  = S_SIFT_RD;
      end
      S_EXT_WR: begin
        cmd.ext_wr = 1'b1;
        state_next = S_SIFT_RD;
      end
      S_SIFT_RD: begin
        cmd.sift_rd = 1'b1;
        state_next  = sts.leaf ? S_PICK : S_SIFT_CMP;
      end
      S_SIFT_CMP: begin
        cmd.sift_cmp = 1'b1;
        state_next   = sts.cont ? S_SIFT_RD : S_PICK;
      end
      S_OUT_RD: begin
        if (sts.out_free) begin
          cmd.out_rd = 1'b1;
          state_next = S_OUT_LD;
        end
      end
      S_OUT_LD: begin
        cmd.out_ld = 1'b1;
        state_next = sts.out_final ? S_LOAD : S_OUT_RD;
      end
      default: begin
        state_next = S_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_LOAD;
    end else begin
      state <= state_next;
    end
  end

endmodule

`default_nettype wire

FILE: hdl/heap_sort_bottom_up_top.sv
// ----------------------------------------------------------------------------
// heap_sort_bottom_up_top
// Collects signed elements, heapsorts them in place and streams them out in
// ascending order.
// ----------------------------------------------------------------------------
//  channel | ports                        | moves
//  --------+------------------------------+----------------------------------
//  item    | item_valid, item_stall, item | one element, last marks end of set
//  res     | res_valid, res_stall, res    | one sorted element per request
//
//  Loading takes one request per cycle; a request is stored only while there is
//  room, else it sets the overflow mark. The sort runs on a one-write, two-read
//  store: each sift reads its start, then reads and compares both children per
//  level the hole moves. Each result is read, then loaded; res_stall holds it.
//  Reset clears the element count and overflow mark; store contents persist.
//  item_stall is high from the last request until the final result is loaded.
// ----------------------------------------------------------------------------
`default_nettype none

module heap_sort_bottom_up_top
  import hsb_pkg::*;
#(
  parameter int STORE_DEPTH = STORE_DEPTH_DEF
) (
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    item_valid,
  output logic         item_stall,
  input  wire in_req_t item,
  output logic         res_valid,
  input  wire logic    res_stall,
  output out_res_t     res
);

  hsb_cmd_t cmd;
  hsb_sts_t sts;

  hsb_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_last  (item.last),
    .item_stall (item_stall),
    .sts        (sts),
    .cmd        (cmd)
  );

  hsb_datapath #(
    .STORE_DEPTH (STORE_DEPTH)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .item      (item),
    .cmd       (cmd),
    .sts       (sts),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res       (res)
  );

endmodule

`default_nettype wire

FILE: bench/tb_heap_sort_bottom_up_top.sv
// ----------------------------------------------------------------------------
// tb_heap_sort_bottom_up_top
// Feeds sets of signed elements to the heapsort block and checks that every
// set comes back in ascending order. The final result of each set carries
// the end mark, and every result of a set that overran the store carries
// the overflow flag. The run covers directed edge sets, then random sets
// under changing sender and receiver pressure.
// ----------------------------------------------------------------------------
module tb_heap_sort_bottom_up_top
  import hsb_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int DEPTH       = STORE_DEPTH_DEF;
  localparam int QUIET_LIMIT = 20000;
  localparam int RAND_ITEMS  = 150;

  // Tracks the set being loaded and the results that the block still owes.
  class sort_checker;
    logic signed [VAL_W-1:0] set_vals[$];
    bit                      set_dropped;
    out_res_t                sorted_due[$];
    int                      errors;
    int                      checked;
    int                      sets_done;
    int                      overflow_sets;

    function void note_item(in_req_t r);
      logic signed [VAL_W-1:0] vals[$];
      logic signed [VAL_W-1:0] key;
      out_res_t                e;
      int                      i;
      int                      j;
      if (set_vals.size() < DEPTH) begin
        set_vals.push_back(r.value);
      end else begin
        set_dropped = 1'b1;
      end
      if (!r.last) return;
      vals = set_vals;
      for (i = 1; i < vals.size(); i++) begin
        key = vals[i];
        j = i - 1;
        while (j >= 0 && vals[j] > key) begin
          vals[j+1] = vals[j];
          j--;
        end
        vals[j+1] = key;
      end
      for (i = 0; i < vals.size(); i++) begin
        e.sorted_value = vals[i];
        e.final_res    = (i == vals.size() - 1);
        e.overflowed   = set_dropped;
        sorted_due.push_back(e);
      end
      sets_done++;
      if (set_dropped) overflow_sets++;
      set_vals.delete();
      set_dropped = 1'b0;
    endfunction

    function void check_result(out_res_t got);
      out_res_t e;
      if (sorted_due.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("unexpected result: value=%0d final=%0b ovf=%0b",
                   got.sorted_value, got.final_res, got.overflowed);
        return;
      end
      e = sorted_due.pop_front();
      checked++;
      if (got.sorted_value !== e.sorted_value || got.final_res !== e.final_res ||
          got.overflowed !== e.overflowed) begin
        errors++;
        if (errors <= 10)
          $display("mismatch on result %0d: expected value=%0d final=%0b ovf=%0b,",
                   checked, e.sorted_value, e.final_res, e.overflowed,
                   " got value=%0d final=%0b ovf=%0b",
                   got.sorted_value, got.final_res, got.overflowed);
      end
    endfunction
  endclass

  logic     clk;
  logic     rst        = 1'b1;
  logic     item_valid = 1'b0;
  logic     item_stall;
  in_req_t  item       = '0;
  logic     res_valid;
  logic     res_stall  = 1'b0;
  out_res_t res;

  sort_checker chk;
  int          gap_pct;
  int          stall_pct;
  int          items_sent;
  int          quiet;

  heap_sort_bottom_up_top DUT (
    .clk       (clk),
    .rst       (rst),
    .item_valid(item_valid),
    .item_stall(item_stall),
    .item      (item),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res       (res)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Receiver: check each accepted result, then pick the next stall.
  always @(posedge clk) begin
    if (rst) begin
      res_stall <= 1'b0;
    end else begin
      if (res_valid && !res_stall) chk.check_result(res);
      res_stall <= ($urandom_range(0, 99) < stall_pct);
    end
  end

  // Watchdog on cycles without any handshake.
  always @(posedge clk) begin
    if (rst || (item_valid && !item_stall) || (res_valid && !res_stall)) begin
      quiet <= 0;
    end else if (quiet >= QUIET_LIMIT) begin
      $display("timeout: no request or result moved for %0d cycles", quiet);
      $display("Simulation FAILED");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  // Hold valid across back-to-back requests; drop it only for a gap.
  task automatic push_item(input logic signed [VAL_W-1:0] v, input logic l);
    in_req_t r;
    int      n;
    r.value = v;
    r.last  = l;
    if ($urandom_range(0, 99) < gap_pct) begin
      item_valid <= 1'b0;
      n = $urandom_range(1, 4);
      repeat (n) @(posedge clk);
    end
    item       <= r;
    item_valid <= 1'b1;
    do @(posedge clk); while (item_stall);
    chk.note_item(r);
    items_sent++;
  endtask

  function automatic logic signed [VAL_W-1:0] pick_value();
    case ($urandom_range(0, 9))
      6, 7:    return $signed($urandom_range(0, 8)) - 4;
      8:       return $urandom_range(0, 1) ? 32'sh7fffffff : 32'sh80000000;
      9:       return $urandom_range(0, 1) ? 32'sd0 : -32'sd1;
      default: return $urandom();
    endcase
  endfunction

  initial begin
    int set_len;
    int set_idx;
    int k;
    int phase;
    chk        = new();
    gap_pct    = 0;
    stall_pct  = 0;
    items_sent = 0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Single-element sets at both extremes.
    push_item(32'sh7fffffff, 1'b1);
    push_item(32'sh80000000, 1'b1);
    // Extremes mixed in one set.
    push_item(32'sd0, 1'b0);
    push_item(-32'sd1, 1'b0);
    push_item(32'sh7fffffff, 1'b0);
    push_item(32'sh80000000, 1'b0);
    push_item(32'sd1, 1'b1);
    // Duplicates.
    push_item(32'sd5, 1'b0);
    push_item(32'sd5, 1'b0);
    push_item(-32'sd5, 1'b0);
    push_item(32'sd5, 1'b1);
    // Already ascending, then descending.
    for (k = 1; k <= 4; k++) push_item(k, k == 4);
    for (k = 4; k >= 1; k--) push_item(k, k == 1);

    // Random sets; one fills the store exactly, one overruns it.
    set_idx = 0;
    while (items_sent < RAND_ITEMS + 19) begin
      if (set_idx == 2) set_len = DEPTH;
      else if (set_idx == 4) set_len = DEPTH + $urandom_range(1, 3);
      else if ($urandom_range(0, 3) == 0) set_len = $urandom_range(9, 20);
      else set_len = $urandom_range(1, 8);
      for (k = 0; k < set_len; k++) begin
        phase = (items_sent - 19) * 4 / RAND_ITEMS;
        case (phase)
          0:       begin gap_pct = 0;  stall_pct = 0;  end
          1:       begin gap_pct = 63; stall_pct = 0;  end
          2:       begin gap_pct = 0;  stall_pct = 63; end
          default: begin gap_pct = 16; stall_pct = 16; end
        endcase
        push_item(pick_value(), k == set_len - 1);
      end
      set_idx++;
    end
    item_valid <= 1'b0;

    while (chk.sorted_due.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);

    $display("sent %0d elements in %0d sets (%0d overran the store)",
             items_sent, chk.sets_done, chk.overflow_sets);
    $display("checked %0d sorted results, %0d mismatches, %0d left owed",
             chk.checked, chk.errors, chk.sorted_due.size());
    if (chk.errors == 0 && chk.sorted_due.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
